>>> design/i2cbb_pkg.sv
package i2cbb_pkg;

    // default width of the tick delay counter
    localparam int unsigned DELAY_BITS_DEF = 20;

    // scl pulses sent at most while freeing a stuck bus
    localparam int unsigned RECOVERY_PULSES = 16;
    localparam int unsigned PULSE_W         = 5;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 20;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
    localparam logic [15:0] EDGE_DELAY_RST  = 16'd0;
    localparam logic [19:0] SETTLE_RST      = 20'd20000;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_WRITE   = 3'd3,
        OP_READ    = 3'd4,
        OP_RECOVER = 3'd5
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HALF_PERIOD = 2'd0,
        CFG_EDGE_DELAY  = 2'd1,
        CFG_SETTLE      = 2'd2
    } cfg_index_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] data_byte;
        logic       nack_last;
        logic       sda_sample;
    } item_t;

    typedef struct packed {
        logic [15:0] half_period;
        logic [15:0] edge_delay;
        logic [19:0] settle;
    } cfg_t;

    typedef struct packed {
        logic       scl_out_enable;
        logic       scl_level;
        logic       sda_out_enable;
        logic       sda_level;
        logic       busy;
        logic       done;
        logic       ack_received;
        logic [7:0] read_data;
        logic       recover_ok;
        logic       command_rejected;
    } result_t;

endpackage

>>> design/i2cbb_seq.sv
module i2cbb_seq #(
    parameter int unsigned DELAY_BITS = i2cbb_pkg::DELAY_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  i2cbb_pkg::item_t  item,
    input  i2cbb_pkg::cfg_t   cfg,
    output i2cbb_pkg::result_t res
);
    import i2cbb_pkg::*;

    typedef enum logic [22:0] {
        PH_IDLE = 23'h000001,
        PH_ST1  = 23'h000002,
        PH_ST2  = 23'h000004,
        PH_FIN  = 23'h000008,
        PH_SP1  = 23'h000010,
        PH_SP2  = 23'h000020,
        PH_WB1  = 23'h000040,
        PH_WB2  = 23'h000080,
        PH_WB3  = 23'h000100,
        PH_WK1  = 23'h000200,
        PH_WK2  = 23'h000400,
        PH_WK3  = 23'h000800,
        PH_RB1  = 23'h001000,
        PH_RB2  = 23'h002000,
        PH_RK1  = 23'h004000,
        PH_RK2  = 23'h008000,
        PH_RV1  = 23'h010000,
        PH_RV3  = 23'h020000,
        PH_RV4  = 23'h040000,
        PH_RP1  = 23'h080000,
        PH_RP2  = 23'h100000,
        PH_RS   = 23'h200000,
        PH_RE   = 23'h400000
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [DELAY_BITS-1:0] delay_reg, delay_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic [PULSE_W-1:0]    pulse_reg, pulse_next;
    logic                  nack_reg, nack_next;
    logic                  ack_reg, ack_next;
    logic                  recover_reg, recover_next;
    logic [7:0]            read_reg, read_next;
    logic                  scl_oe_reg, scl_oe_next;
    logic                  scl_lv_reg, scl_lv_next;
    logic                  sda_oe_reg, sda_oe_next;
    logic                  sda_lv_reg, sda_lv_next;

    logic                  done;
    logic                  rejected;
    logic                  do_wb0;
    logic                  do_rb0;
    logic                  do_rv2;
    logic                  do_rp0;
    logic [DELAY_BITS-1:0] dec;
    logic [DELAY_BITS-1:0] hp;
    logic [DELAY_BITS-1:0] ed;
    logic [DELAY_BITS-1:0] st;
    logic [PULSE_W-1:0]    pulse_inc;
    logic                  sda;

    assign hp        = DELAY_BITS'(cfg.half_period);
    assign ed        = DELAY_BITS'(cfg.edge_delay);
    assign st        = DELAY_BITS'(cfg.settle);
    assign pulse_inc = pulse_reg + PULSE_W'(1);
    assign sda       = item.sda_sample;

    always_comb
    begin
        phase_next   = phase_reg;
        delay_next   = delay_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        pulse_next   = pulse_reg;
        nack_next    = nack_reg;
        ack_next     = ack_reg;
        recover_next = recover_reg;
        read_next    = read_reg;
        scl_oe_next  = scl_oe_reg;
        scl_lv_next  = scl_lv_reg;
        sda_oe_next  = sda_oe_reg;
        sda_lv_next  = sda_lv_reg;
        done         = 1'b0;
        rejected     = 1'b0;
        do_wb0       = 1'b0;
        do_rb0       = 1'b0;
        do_rv2       = 1'b0;
        do_rp0       = 1'b0;
        dec          = '0;
        if (step)
        begin
            unique case (item.opcode)
                OP_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        dec        = (delay_reg != '0) ? delay_reg - DELAY_BITS'(1) : '0;
                        delay_next = dec;
                        if (dec == '0)
                        begin
                            unique case (phase_reg)
                                PH_ST1:
                                begin
                                    sda_oe_next = 1'b1;
                                    sda_lv_next = 1'b0;
                                    delay_next  = ed;
                                    phase_next  = PH_ST2;
                                end
                                PH_ST2:
                                begin
                                    scl_oe_next = 1'b1;
                                    scl_lv_next = 1'b0;
                                    delay_next  = ed;
                                    phase_next  = PH_FIN;
                                end
                                PH_SP1:
                                begin
                                    scl_oe_next = 1'b0;
                                    delay_next  = ed;
                                    phase_next  = PH_SP2;
                                end
                                PH_SP2:
                                begin
                                    sda_oe_next = 1'b0;
                                    delay_next  = ed;
                                    phase_next  = PH_FIN;
                                end
                                PH_WB1:
                                begin
                                    scl_lv_next = 1'b1;
                                    delay_next  = hp;
                                    phase_next  = PH_WB2;
                                end
                                PH_WB2:
                                begin
                                    scl_lv_next = 1'b0;
                                    delay_next  = hp;
                                    phase_next  = PH_WB3;
                                end
                                PH_WB3:
                                begin
                                    if (bit_reg != 3'd0)
                                    begin
                                        bit_next = bit_reg - 3'd1;
                                        do_wb0   = 1'b1;
                                    end
                                    else
                                    begin
                                        sda_oe_next = 1'b0;
                                        delay_next  = hp;
                                        phase_next  = PH_WK1;
                                    end
                                end
                                PH_WK1:
                                begin
                                    scl_lv_next = 1'b1;
                                    delay_next  = hp;
                                    phase_next  = PH_WK2;
                                end
                                PH_WK2:
                                begin
                                    ack_next    = ~sda;
                                    scl_lv_next = 1'b0;
                                    delay_next  = hp;
                                    phase_next  = PH_WK3;
                                end
                                PH_WK3:
                                begin
                                    sda_oe_next = 1'b1;
                                    phase_next  = PH_IDLE;
                                    delay_next  = '0;
                                    done        = 1'b1;
                                end
                                PH_RB1:
                                begin
                                    shift_next[bit_reg] = shift_reg[bit_reg] | sda;
                                    scl_lv_next         = 1'b0;
                                    delay_next          = hp;
                                    phase_next          = PH_RB2;
                                end
                                PH_RB2:
                                begin
                                    if (bit_reg != 3'd0)
                                    begin
                                        bit_next = bit_reg - 3'd1;
                                        do_rb0   = 1'b1;
                                    end
                                    else
                                    begin
                                        sda_oe_next = 1'b1;
                                        sda_lv_next = nack_reg;
                                        delay_next  = hp;
                                        phase_next  = PH_RK1;
                                    end
                                end
                                PH_RK1:
                                begin
                                    scl_lv_next = 1'b1;
                                    delay_next  = hp;
                                    phase_next  = PH_RK2;
                                end
                                PH_RK2:
                                begin
                                    scl_lv_next = 1'b0;
                                    sda_lv_next = 1'b1;
                                    read_next   = shift_reg;
                                    phase_next  = PH_IDLE;
                                    delay_next  = '0;
                                    done        = 1'b1;
                                end
                                PH_RV1:
                                begin
                                    if (sda)
                                    begin
                                        do_rp0 = 1'b1;
                                    end
                                    else
                                    begin
                                        scl_oe_next = 1'b1;
                                        pulse_next  = '0;
                                        do_rv2      = 1'b1;
                                    end
                                end
                                PH_RV3:
                                begin
                                    scl_lv_next = 1'b1;
                                    delay_next  = hp;
                                    phase_next  = PH_RV4;
                                end
                                PH_RV4:
                                begin
                                    pulse_next = pulse_inc;
                                    if (sda || (pulse_inc >= PULSE_W'(RECOVERY_PULSES)))
                                    begin
                                        do_rp0 = 1'b1;
                                    end
                                    else
                                    begin
                                        do_rv2 = 1'b1;
                                    end
                                end
                                PH_RP1:
                                begin
                                    scl_oe_next = 1'b0;
                                    delay_next  = hp;
                                    phase_next  = PH_RP2;
                                end
                                PH_RP2:
                                begin
                                    sda_oe_next = 1'b0;
                                    delay_next  = hp;
                                    phase_next  = PH_RS;
                                end
                                PH_RS:
                                begin
                                    delay_next = st;
                                    phase_next = PH_RE;
                                end
                                PH_RE:
                                begin
                                    recover_next = sda;
                                    phase_next   = PH_IDLE;
                                    delay_next   = '0;
                                    done         = 1'b1;
                                end
                                default:
                                begin
                                    // end of start or stop condition
                                    phase_next = PH_IDLE;
                                    delay_next = '0;
                                    done       = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                OP_START, OP_STOP, OP_WRITE, OP_READ, OP_RECOVER:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        rejected = 1'b1;
                    end
                    else
                    begin
                        unique case (item.opcode)
                            OP_START:
                            begin
                                scl_oe_next = 1'b0;
                                sda_oe_next = 1'b0;
                                delay_next  = ed;
                                phase_next  = PH_ST1;
                            end
                            OP_STOP:
                            begin
                                sda_oe_next = 1'b1;
                                sda_lv_next = 1'b0;
                                delay_next  = ed;
                                phase_next  = PH_SP1;
                            end
                            OP_WRITE:
                            begin
                                shift_next = item.data_byte;
                                bit_next   = 3'd7;
                                do_wb0     = 1'b1;
                            end
                            OP_READ:
                            begin
                                nack_next   = item.nack_last;
                                shift_next  = '0;
                                bit_next    = 3'd7;
                                sda_oe_next = 1'b0;
                                do_rb0      = 1'b1;
                            end
                            default:
                            begin
                                scl_oe_next = 1'b0;
                                sda_oe_next = 1'b0;
                                delay_next  = hp;
                                phase_next  = PH_RV1;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase

            // shared bit-phase actions
            if (do_wb0)
            begin
                sda_oe_next = 1'b1;
                sda_lv_next = shift_next[bit_next];
                delay_next  = hp;
                phase_next  = PH_WB1;
            end
            if (do_rb0)
            begin
                scl_lv_next = 1'b1;
                delay_next  = hp;
                phase_next  = PH_RB1;
            end
            if (do_rv2)
            begin
                scl_lv_next = 1'b0;
                delay_next  = hp;
                phase_next  = PH_RV3;
            end
            if (do_rp0)
            begin
                sda_oe_next = 1'b1;
                sda_lv_next = 1'b0;
                delay_next  = hp;
                phase_next  = PH_RP1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            delay_reg   <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            pulse_reg   <= '0;
            nack_reg    <= 1'b0;
            ack_reg     <= 1'b0;
            recover_reg <= 1'b0;
            read_reg    <= '0;
            scl_oe_reg  <= 1'b0;
            scl_lv_reg  <= 1'b1;
            sda_oe_reg  <= 1'b0;
            sda_lv_reg  <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            delay_reg   <= delay_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            pulse_reg   <= pulse_next;
            nack_reg    <= nack_next;
            ack_reg     <= ack_next;
            recover_reg <= recover_next;
            read_reg    <= read_next;
            scl_oe_reg  <= scl_oe_next;
            scl_lv_reg  <= scl_lv_next;
            sda_oe_reg  <= sda_oe_next;
            sda_lv_reg  <= sda_lv_next;
        end
    end

    always_comb
    begin
        res.scl_out_enable   = scl_oe_next;
        res.scl_level        = scl_lv_next;
        res.sda_out_enable   = sda_oe_next;
        res.sda_level        = sda_lv_next;
        res.busy             = (phase_next != PH_IDLE);
        res.done             = done;
        res.ack_received     = ack_next;
        res.read_data        = read_next;
        res.recover_ok       = recover_next;
        res.command_rejected = rejected;
    end

endmodule

>>> design/i2c_bit_bang_master_unit.sv
// channel   direction  handshake               payload
// input     in         in_valid / in_stall     opcode, data_byte, nack_last, sda_sample
// result    out        out_valid / out_stall   pin drive, busy, done, ack, read data, status
// config    in         cfg_we                  cfg_index, cfg_data
//
// one beat in, one beat out; a beat can be taken every clock cycle while the result is not stalled
// a beat passes the input register, then a sequencer step into the result register
// the pace is set by the single sequencer step between input and result registers
// async active-low reset releases both lines, idles the sequencer, loads register defaults
// a stalled result holds the result register; the input register then fills and stalls in
module i2c_bit_bang_master_unit #(
    parameter int unsigned DELAY_BITS = i2cbb_pkg::DELAY_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // command and tick beats
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        opcode,
    input  logic [7:0]                        data_byte,
    input  logic                              nack_last,
    input  logic                              sda_sample,

    // result beats
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              scl_out_enable,
    output logic                              scl_level,
    output logic                              sda_out_enable,
    output logic                              sda_level,
    output logic                              busy_res,
    output logic                              done_res,
    output logic                              ack_received,
    output logic [7:0]                        read_data,
    output logic                              recover_ok,
    output logic                              command_rejected,

    // register writes
    input  logic                              cfg_we,
    input  logic [i2cbb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [i2cbb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import i2cbb_pkg::*;

    // input register
    logic    in_vld_reg, in_vld_next;
    item_t   item_reg;

    // result register
    logic    out_vld_reg, out_vld_next;
    result_t res_reg;
    result_t seq_res;

    // configuration registers
    cfg_t    cfg_reg;

    logic    step;
    logic    in_take;

    // the sequencer steps when an input beat waits and the result slot is free
    assign step     = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !step;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (step)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode     <= opcode_t'(opcode);
            item_reg.data_byte  <= data_byte;
            item_reg.nack_last  <= nack_last;
            item_reg.sda_sample <= sda_sample;
        end
        if (step)
        begin
            res_reg <= seq_res;
        end
    end

    // register writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period <= HALF_PERIOD_RST;
            cfg_reg.edge_delay  <= EDGE_DELAY_RST;
            cfg_reg.settle      <= SETTLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HALF_PERIOD: cfg_reg.half_period <= cfg_data[15:0];
                CFG_EDGE_DELAY:  cfg_reg.edge_delay  <= cfg_data[15:0];
                CFG_SETTLE:      cfg_reg.settle      <= cfg_data[19:0];
                default:
                begin
                end
            endcase
        end
    end

    // pin sequencer: phase, tick delay, bit shifter and held status
    i2cbb_seq #(
        .DELAY_BITS (DELAY_BITS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (seq_res)
    );

    assign out_valid        = out_vld_reg;
    assign scl_out_enable   = res_reg.scl_out_enable;
    assign scl_level        = res_reg.scl_level;
    assign sda_out_enable   = res_reg.sda_out_enable;
    assign sda_level        = res_reg.sda_level;
    assign busy_res         = res_reg.busy;
    assign done_res         = res_reg.done;
    assign ack_received     = res_reg.ack_received;
    assign read_data        = res_reg.read_data;
    assign recover_ok       = res_reg.recover_ok;
    assign command_rejected = res_reg.command_rejected;

    // a finished sequence leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    // a rejected command only happens while a sequence runs
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_rejected |-> busy_res && !done_res)
        else $error("command rejected while idle or finishing");

    // the input side only stalls while the input register holds a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg && out_stall)
        else $error("input stalled without a blocked result");

    // every stepped beat shows up as a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("stepped beat produced no result");

endmodule
